[hdl/lfsc_pkg.sv]
// Package for the line-follow steering control block.
// Holds field widths, register map, reset values, drive and class codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package lfsc_pkg;

    localparam int LEVEL_W = 12;
    localparam int DUTY_W  = 10;
    localparam int HOLD_W  = 8;
    localparam int HIST_W  = 3;
    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    // register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_FAST_DUTY      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOW_DUTY      = 3'd2;
    localparam logic [IDX_W-1:0] REG_GENTLE_HOLD    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHARP_HOLD     = 3'd4;
    localparam logic [IDX_W-1:0] REG_SLOW_MARGIN    = 3'd5;

    localparam logic [LEVEL_W-1:0] LINE_THRESHOLD_RST = 12'd1000;
    localparam logic [DUTY_W-1:0]  FAST_DUTY_RST      = 10'd500;
    localparam logic [DUTY_W-1:0]  SLOW_DUTY_RST      = 10'd230;
    localparam logic [HOLD_W-1:0]  GENTLE_HOLD_RST    = 8'd60;
    localparam logic [HOLD_W-1:0]  SHARP_HOLD_RST     = 8'd62;
    localparam logic [HOLD_W-1:0]  SLOW_MARGIN_RST    = 8'd2;

    // item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // active mode: none entered yet, otherwise class + 1
    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;

    // turn history codes
    localparam logic [HIST_W-1:0] HIST_CLEAR            = 3'd0;
    localparam logic [HIST_W-1:0] HIST_LEFT_FIRST       = 3'd1;
    localparam logic [HIST_W-1:0] HIST_RIGHT_AFTER_LEFT = 3'd2;
    localparam logic [HIST_W-1:0] HIST_RIGHT_FIRST      = 3'd3;
    localparam logic [HIST_W-1:0] HIST_LEFT_AFTER_RIGHT = 3'd4;

    typedef enum logic [1:0] {
        DRV_COAST = 2'd0,
        DRV_FWD   = 2'd1,
        DRV_BRAKE = 2'd2
    } t_drive;

    typedef enum logic [2:0] {
        CLS_STRAIGHT     = 3'd0,
        CLS_GENTLE_LEFT  = 3'd1,
        CLS_GENTLE_RIGHT = 3'd2,
        CLS_SHARP_RIGHT  = 3'd3,
        CLS_SHARP_LEFT   = 3'd4
    } t_class;

    typedef struct packed {
        logic [LEVEL_W-1:0] line_threshold;
        logic [DUTY_W-1:0]  fast_duty;
        logic [DUTY_W-1:0]  slow_duty;
        logic [HOLD_W-1:0]  gentle_hold;
        logic [HOLD_W-1:0]  sharp_hold;
        logic [HOLD_W-1:0]  slow_margin;
    } t_cfg;

    typedef struct packed {
        t_drive            left_drive;
        logic [DUTY_W-1:0] left_duty;
        t_drive            right_drive;
        logic [DUTY_W-1:0] right_duty;
        t_class            steer_class;
    } t_motor;

endpackage

[hdl/lfsc_stream_if.sv]
// Valid/ready stream interfaces for the steering control input and result channels.
// Depends on lfsc_pkg for field widths.
`timescale 1ns / 1ps

interface lfsc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [lfsc_pkg::LEVEL_W-1:0] right_level;
    logic [lfsc_pkg::LEVEL_W-1:0] left_level;
    logic                         right_outer;
    logic                         left_outer;

    modport source (output valid, func, right_level, left_level, right_outer, left_outer,
                    input ready);
    modport sink   (input valid, func, right_level, left_level, right_outer, left_outer,
                    output ready);
endinterface

interface lfsc_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  left_drive;
    logic [lfsc_pkg::DUTY_W-1:0] left_duty;
    logic [1:0]                  right_drive;
    logic [lfsc_pkg::DUTY_W-1:0] right_duty;
    logic [2:0]                  steer_class;

    modport source (output valid, left_drive, left_duty, right_drive, right_duty, steer_class,
                    input ready);
    modport sink   (input valid, left_drive, left_duty, right_drive, right_duty, steer_class,
                    output ready);
endinterface

[hdl/lfsc_cfg.sv]
// APB-style configuration register file for the steering control block.
// Depends on lfsc_pkg for the register map and reset values.
`timescale 1ns / 1ps

module lfsc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfsc_pkg::ADDR_W-1:0] paddr,
    input  logic [lfsc_pkg::DATA_W-1:0] pwdata,
    output logic [lfsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lfsc_pkg::t_cfg              o_cfg
);

    lfsc_pkg::t_cfg              r_cfg;
    logic                        wr_en;
    logic [lfsc_pkg::IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[lfsc_pkg::ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_threshold <= lfsc_pkg::LINE_THRESHOLD_RST;
            r_cfg.fast_duty      <= lfsc_pkg::FAST_DUTY_RST;
            r_cfg.slow_duty      <= lfsc_pkg::SLOW_DUTY_RST;
            r_cfg.gentle_hold    <= lfsc_pkg::GENTLE_HOLD_RST;
            r_cfg.sharp_hold     <= lfsc_pkg::SHARP_HOLD_RST;
            r_cfg.slow_margin    <= lfsc_pkg::SLOW_MARGIN_RST;
        end else if (wr_en) begin
            case (idx)
                lfsc_pkg::REG_LINE_THRESHOLD: begin
                    r_cfg.line_threshold <= pwdata[lfsc_pkg::LEVEL_W-1:0];
                end
                lfsc_pkg::REG_FAST_DUTY: begin
                    r_cfg.fast_duty <= pwdata[lfsc_pkg::DUTY_W-1:0];
                end
                lfsc_pkg::REG_SLOW_DUTY: begin
                    r_cfg.slow_duty <= pwdata[lfsc_pkg::DUTY_W-1:0];
                end
                lfsc_pkg::REG_GENTLE_HOLD: begin
                    r_cfg.gentle_hold <= pwdata[lfsc_pkg::HOLD_W-1:0];
                end
                lfsc_pkg::REG_SHARP_HOLD: begin
                    r_cfg.sharp_hold <= pwdata[lfsc_pkg::HOLD_W-1:0];
                end
                lfsc_pkg::REG_SLOW_MARGIN: begin
                    r_cfg.slow_margin <= pwdata[lfsc_pkg::HOLD_W-1:0];
                end
                default: begin
                    // unmapped: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            lfsc_pkg::REG_LINE_THRESHOLD: prdata = lfsc_pkg::DATA_W'(r_cfg.line_threshold);
            lfsc_pkg::REG_FAST_DUTY:      prdata = lfsc_pkg::DATA_W'(r_cfg.fast_duty);
            lfsc_pkg::REG_SLOW_DUTY:      prdata = lfsc_pkg::DATA_W'(r_cfg.slow_duty);
            lfsc_pkg::REG_GENTLE_HOLD:    prdata = lfsc_pkg::DATA_W'(r_cfg.gentle_hold);
            lfsc_pkg::REG_SHARP_HOLD:     prdata = lfsc_pkg::DATA_W'(r_cfg.sharp_hold);
            lfsc_pkg::REG_SLOW_MARGIN:    prdata = lfsc_pkg::DATA_W'(r_cfg.slow_margin);
            default:                      prdata = '0;
        endcase
    end

endmodule

[hdl/lfsc_steer.sv]
// Steering state: classification, mode entry, turn history and hold countdown.
// Depends on lfsc_pkg; updates its state when the top level advances an item.
`timescale 1ns / 1ps

module lfsc_steer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_func,
    input  logic [lfsc_pkg::LEVEL_W-1:0] i_right_level,
    input  logic [lfsc_pkg::LEVEL_W-1:0] i_left_level,
    input  logic                         i_right_outer,
    input  logic                         i_left_outer,
    input  lfsc_pkg::t_cfg               i_cfg,
    output lfsc_pkg::t_motor             o_next
);

    lfsc_pkg::t_motor            r_state, n_state;
    logic [lfsc_pkg::MODE_W-1:0] r_active, n_active;
    logic [lfsc_pkg::HIST_W-1:0] r_hist, n_hist;
    logic [lfsc_pkg::HOLD_W-1:0] r_hold, n_hold;

    lfsc_pkg::t_class            cls;
    logic                        entering;
    logic                        above_l, below_l, above_r, below_r;
    logic [lfsc_pkg::DUTY_W-1:0] run_duty;

    assign above_l  = i_left_level > i_cfg.line_threshold;
    assign below_l  = i_left_level < i_cfg.line_threshold;
    assign above_r  = i_right_level > i_cfg.line_threshold;
    assign below_r  = i_right_level < i_cfg.line_threshold;
    assign run_duty = (r_hold > i_cfg.slow_margin) ? i_cfg.fast_duty : i_cfg.slow_duty;
    assign o_next   = n_state;

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_hist   = r_hist;
        n_hold   = r_hold;
        cls      = r_state.steer_class;
        entering = 1'b0;

        if (i_func == lfsc_pkg::FUNC_TICK) begin
            if (r_hold != '0) begin
                n_hold = r_hold - lfsc_pkg::HOLD_W'(1);
            end
        end else begin
            if (above_l && above_r && i_right_outer && i_left_outer
                    && r_hist == lfsc_pkg::HIST_CLEAR) begin
                cls = lfsc_pkg::CLS_STRAIGHT;
            end else if (i_left_outer && below_l && above_r && i_right_outer
                    && (r_hist inside {lfsc_pkg::HIST_CLEAR,
                                       lfsc_pkg::HIST_RIGHT_AFTER_LEFT})) begin
                cls = lfsc_pkg::CLS_GENTLE_LEFT;
            end else if (i_left_outer && above_l && below_r && i_right_outer
                    && (r_hist inside {lfsc_pkg::HIST_CLEAR,
                                       lfsc_pkg::HIST_LEFT_AFTER_RIGHT})) begin
                cls = lfsc_pkg::CLS_GENTLE_RIGHT;
            end else if (!i_right_outer && i_left_outer) begin
                cls = lfsc_pkg::CLS_SHARP_RIGHT;
            end else if (!i_left_outer && i_right_outer) begin
                cls = lfsc_pkg::CLS_SHARP_LEFT;
            end
            // no rule matched: keep the held class

            n_state.steer_class = cls;
            entering = r_active != (lfsc_pkg::MODE_W'(cls) + lfsc_pkg::MODE_W'(1));

            case (cls)
                lfsc_pkg::CLS_STRAIGHT: begin
                    n_state.left_drive  = lfsc_pkg::DRV_FWD;
                    n_state.right_drive = lfsc_pkg::DRV_FWD;
                    if (entering) begin
                        n_hist             = lfsc_pkg::HIST_CLEAR;
                        n_hold             = i_cfg.gentle_hold;
                        n_state.left_duty  = i_cfg.fast_duty;
                        n_state.right_duty = i_cfg.fast_duty;
                    end else begin
                        n_state.left_duty  = run_duty;
                        n_state.right_duty = run_duty;
                    end
                end
                lfsc_pkg::CLS_GENTLE_LEFT: begin
                    n_state.right_drive = lfsc_pkg::DRV_FWD;
                    if (entering) begin
                        n_hist             = lfsc_pkg::HIST_CLEAR;
                        n_hold             = i_cfg.gentle_hold;
                        n_state.left_drive = lfsc_pkg::DRV_BRAKE;
                        n_state.right_duty = i_cfg.fast_duty;
                    end else begin
                        n_state.right_duty = run_duty;
                    end
                end
                lfsc_pkg::CLS_GENTLE_RIGHT: begin
                    n_state.left_drive = lfsc_pkg::DRV_FWD;
                    if (entering) begin
                        n_hist              = lfsc_pkg::HIST_CLEAR;
                        n_hold              = i_cfg.gentle_hold;
                        n_state.right_drive = lfsc_pkg::DRV_BRAKE;
                        n_state.left_duty   = i_cfg.fast_duty;
                    end else begin
                        n_state.left_duty = run_duty;
                    end
                end
                lfsc_pkg::CLS_SHARP_RIGHT: begin
                    n_state.right_drive = lfsc_pkg::DRV_BRAKE;
                    n_state.left_drive  = lfsc_pkg::DRV_FWD;
                    if (entering) begin
                        if (r_hist == lfsc_pkg::HIST_CLEAR) begin
                            n_hist = lfsc_pkg::HIST_RIGHT_FIRST;
                        end else if (r_hist == lfsc_pkg::HIST_LEFT_FIRST) begin
                            n_hist = lfsc_pkg::HIST_RIGHT_AFTER_LEFT;
                        end
                        n_hold            = i_cfg.sharp_hold;
                        n_state.left_duty = i_cfg.fast_duty;
                    end else begin
                        n_state.left_duty = run_duty;
                    end
                end
                default: begin
                    // sharp left
                    n_state.left_drive  = lfsc_pkg::DRV_BRAKE;
                    n_state.right_drive = lfsc_pkg::DRV_FWD;
                    if (entering) begin
                        if (r_hist == lfsc_pkg::HIST_CLEAR) begin
                            n_hist = lfsc_pkg::HIST_LEFT_FIRST;
                        end else if (r_hist == lfsc_pkg::HIST_RIGHT_FIRST) begin
                            n_hist = lfsc_pkg::HIST_LEFT_AFTER_RIGHT;
                        end
                        n_hold             = i_cfg.sharp_hold;
                        n_state.right_duty = i_cfg.fast_duty;
                    end else begin
                        n_state.right_duty = run_duty;
                    end
                end
            endcase

            if (entering) begin
                n_active = lfsc_pkg::MODE_W'(cls) + lfsc_pkg::MODE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.left_drive  <= lfsc_pkg::DRV_COAST;
            r_state.left_duty   <= '0;
            r_state.right_drive <= lfsc_pkg::DRV_COAST;
            r_state.right_duty  <= '0;
            r_state.steer_class <= lfsc_pkg::CLS_STRAIGHT;
            r_active            <= lfsc_pkg::MODE_NONE;
            r_hist              <= lfsc_pkg::HIST_CLEAR;
            r_hold              <= '0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_active <= n_active;
            r_hist   <= n_hist;
            r_hold   <= n_hold;
        end
    end

    // a braking turn class always leaves the inner wheel braked
    a_sharp_right_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.steer_class == lfsc_pkg::CLS_SHARP_RIGHT |-> r_state.right_drive == lfsc_pkg::DRV_BRAKE)
        else $error("sharp right without right brake");

    a_left_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.steer_class == lfsc_pkg::CLS_SHARP_LEFT
         || r_state.steer_class == lfsc_pkg::CLS_GENTLE_LEFT)
        |-> r_state.left_drive == lfsc_pkg::DRV_BRAKE)
        else $error("left turn without left brake");

    a_active_tracks_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == lfsc_pkg::MODE_NONE
        || r_active == (lfsc_pkg::MODE_W'(r_state.steer_class) + lfsc_pkg::MODE_W'(1)))
        else $error("active mode out of step with class");

    a_tick_keeps_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_func == lfsc_pkg::FUNC_TICK |=> $stable(r_state))
        else $error("tick changed motor state");

    a_tick_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_func == lfsc_pkg::FUNC_TICK && r_hold != '0
        |=> r_hold == $past(r_hold) - lfsc_pkg::HOLD_W'(1))
        else $error("tick did not decrement countdown");

endmodule

[hdl/line_follow_steering_control.sv]
// Top level of the line-follow steering control block.
// Depends on lfsc_pkg, lfsc_stream_if, lfsc_cfg and lfsc_steer.
`timescale 1ns / 1ps

// Usage:
// i_in carries one transaction per control sample (func 0: two analog line
// levels and two outer sensors) or per millisecond tick (func 1). Every input
// transaction yields exactly one result transaction on o_out: both motor
// drives and duties and the steering class held after that item.
// Path: an accepted transaction goes through the input register and then the
// result register to o_out. Throughput: one transaction per cycle while o_out
// is not stalled, set by the single pass from the input register through the
// classifier into the result register and the steering state.
// Stall: when o_out.ready is low the result is held; one more transaction
// is taken into the input register, then i_in.ready drops until o_out
// drains. i_in.ready depends combinationally on o_out.ready.
// Reset (i_rst_n low, synchronous): both channels empty, motors coast with
// duty 0, class straight, no mode entered, history and countdown cleared,
// configuration registers back to their defaults.
// Configuration: APB-style, register i at byte address 4*i, pready always
// high; write only while no transaction is in flight.

module line_follow_steering_control (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lfsc_in_if.sink                     i_in,
    lfsc_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfsc_pkg::ADDR_W-1:0] paddr,
    input  logic [lfsc_pkg::DATA_W-1:0] pwdata,
    output logic [lfsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    lfsc_pkg::t_cfg   cfg;
    lfsc_pkg::t_motor next_motor;

    logic                         r_s1_valid;
    logic                         r_s1_func;
    logic [lfsc_pkg::LEVEL_W-1:0] r_s1_right_level;
    logic [lfsc_pkg::LEVEL_W-1:0] r_s1_left_level;
    logic                         r_s1_right_outer;
    logic                         r_s1_left_outer;

    logic                         r_out_valid;
    lfsc_pkg::t_motor             r_out;

    logic in_acc;
    logic s1_adv;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    lfsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfsc_steer u_steer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (s1_adv),
        .i_func        (r_s1_func),
        .i_right_level (r_s1_right_level),
        .i_left_level  (r_s1_left_level),
        .i_right_outer (r_s1_right_outer),
        .i_left_outer  (r_s1_left_outer),
        .i_cfg         (cfg),
        .o_next        (next_motor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func        <= i_in.func;
            r_s1_right_level <= i_in.right_level;
            r_s1_left_level  <= i_in.left_level;
            r_s1_right_outer <= i_in.right_outer;
            r_s1_left_outer  <= i_in.left_outer;
        end
        if (s1_adv) begin
            r_out <= next_motor;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_drive  = r_out.left_drive;
    assign o_out.left_duty   = r_out.left_duty;
    assign o_out.right_drive = r_out.right_drive;
    assign o_out.right_duty  = r_out.right_duty;
    assign o_out.steer_class = r_out.steer_class;

endmodule
